// File: hw/rtl/sdsm_pkg.sv
// Shared types and constants for the stick deadzone / sensitivity merge block.
package sdsm_pkg;

  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 16;

  localparam logic [15:0] AxisMax      = 16'h7fff;
  localparam logic [15:0] AxisMinusMax = 16'h8001;
  localparam logic [11:0] SensReset    = 12'd256;
  localparam logic [15:0] DzReset      = 16'd0;

  typedef enum logic {
    REG_DEADZONE    = 1'b0,
    REG_SENSITIVITY = 1'b1
  } reg_idx_e;

  // Everything one request carries down the pipeline.
  typedef struct packed {
    logic [15:0] vmag;
    logic        vneg;
    logic        vnz;
    logic        active;
    logic        plus;
    logic        minus;
    logic [30:0] xx;
    logic [30:0] yy;
    logic [31:0] sq;
    logic [15:0] root;
    logic [17:0] srem;
    logic        le_dz;
    logic [30:0] pvn;
    logic [30:0] pdr;
    logic [45:0] num;
    logic [30:0] den;
    logic [15:0] quo;
    logic [15:0] mag;
    logic [27:0] gp;
  } item_t;

endpackage

// File: hw/rtl/sdsm_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module sdsm_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  sdsm_pkg::item_t item_i,
  output logic           valid_o,
  output sdsm_pkg::item_t item_o
);

  logic            valid_q;
  sdsm_pkg::item_t item_q, item_d;
  logic [19:0]     rem_w;
  logic [19:0]     trial;

  always_comb begin
    item_d = item_i;
    rem_w  = {item_i.srem, item_i.sq[31:30]};
    trial  = {2'b00, item_i.root, 2'b01};
    item_d.sq = {item_i.sq[29:0], 2'b00};
    if (rem_w >= trial) begin
      item_d.srem = 18'(rem_w - trial);
      item_d.root = {item_i.root[14:0], 1'b1};
    end else begin
      item_d.srem = rem_w[17:0];
      item_d.root = {item_i.root[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/sdsm_div_cell.sv
// One quotient bit of the pipelined restoring divider.
module sdsm_div_cell #(
  parameter int unsigned BIT = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  sdsm_pkg::item_t item_i,
  output logic           valid_o,
  output sdsm_pkg::item_t item_o
);

  logic            valid_q;
  sdsm_pkg::item_t item_q, item_d;
  logic [45:0]     den_sh;

  always_comb begin
    item_d = item_i;
    den_sh = {15'b0, item_i.den} << BIT;
    if (item_i.num >= den_sh) begin
      item_d.num      = item_i.num - den_sh;
      item_d.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/stick_deadzone_sensitivity_merge_core.sv
// Stick deadzone, sensitivity and key merge: top level pipeline.
// Takes one request per cycle and carries it through these registered stages: two input
// stages, a 16-cell square root chain, two product stages, a 16-cell divider chain,
// a gain stage and the output register. The whole chain advances together, so a
// stalled output holds every stage; with the output taken each cycle the rate is
// one request per clock. Write the configuration only while the pipeline is empty.
module stick_deadzone_sensitivity_merge_core #(
  parameter int unsigned SENS_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] stick_x, [31:16] stick_y, [32] remote_active, [33] local_plus,
  // [34] local_minus, rest zero
  input  logic [39:0] s_axis_tdata,
  // [0] axis_is_y
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] axis_value
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [12:0] SensUnity = 13'(1 << SENS_FRAC_BITS);

  logic [15:0] dz_q;
  logic [11:0] sens_q;
  logic        en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q   <= sdsm_pkg::DzReset;
      sens_q <= sdsm_pkg::SensReset;
    end else if (cfg_we_i) begin
      unique case (sdsm_pkg::reg_idx_e'(cfg_idx_i))
        sdsm_pkg::REG_DEADZONE:    dz_q   <= cfg_data_i;
        sdsm_pkg::REG_SENSITIVITY: sens_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Deadzone radius and remaining span follow the register directly.
  logic [30:0] dz_prod;
  logic [14:0] dzr;
  logic [14:0] span;
  assign dz_prod = {dz_q, 15'b0} - {15'b0, dz_q};
  assign dzr     = dz_prod[30:16];
  assign span    = 15'(sdsm_pkg::AxisMax - {1'b0, dzr});

  logic out_valid_q;
  logic [15:0] out_data_q, out_data_d;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: pick the axis, take magnitude, square both axes.
  logic            a_valid_q;
  sdsm_pkg::item_t a_q, a_d;
  logic signed [15:0] in_x, in_y, in_v;

  always_comb begin
    in_x = s_axis_tdata[15:0];
    in_y = s_axis_tdata[31:16];
    in_v = s_axis_tuser ? in_y : in_x;
    a_d        = '0;
    a_d.vneg   = in_v[15];
    a_d.vmag   = in_v[15] ? 16'(-in_v) : in_v;
    a_d.vnz    = in_v != 16'sd0;
    a_d.active = s_axis_tdata[32];
    a_d.plus   = s_axis_tdata[33];
    a_d.minus  = s_axis_tdata[34];
    a_d.xx     = 31'(in_x * in_x);
    a_d.yy     = 31'(in_y * in_y);
  end

  // Stage B: sum of squares.
  logic            b_valid_q;
  sdsm_pkg::item_t b_q, b_d;

  always_comb begin
    b_d      = a_q;
    b_d.sq   = {1'b0, a_q.xx} + {1'b0, a_q.yy};
    b_d.root = '0;
    b_d.srem = '0;
  end

  logic            sq_vld [0:sdsm_pkg::SqrtSteps];
  sdsm_pkg::item_t sq_it  [0:sdsm_pkg::SqrtSteps];
  assign sq_vld[0] = b_valid_q;
  assign sq_it[0]  = b_q;

  for (genvar g = 0; g < sdsm_pkg::SqrtSteps; g++) begin : g_sqrt
    sdsm_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[g]),
      .item_i  (sq_it[g]),
      .valid_o (sq_vld[g+1]),
      .item_o  (sq_it[g+1])
    );
  end

  // Stage C: deadzone test and the two products.
  logic            c_valid_q;
  sdsm_pkg::item_t c_q, c_d;
  sdsm_pkg::item_t c_in;
  logic [15:0]     excess;
  logic [14:0]     nlim;

  always_comb begin
    c_in     = sq_it[sdsm_pkg::SqrtSteps];
    c_d      = c_in;
    c_d.le_dz = c_in.root <= {1'b0, dzr};
    excess   = c_in.root - {1'b0, dzr};
    nlim     = (excess > {1'b0, span}) ? span : excess[14:0];
    c_d.pvn  = 31'(c_in.vmag * nlim);
    c_d.pdr  = 31'(span * c_in.root);
  end

  // Stage D: beyond full scale fold in 32767 / r.
  logic            d_valid_q;
  sdsm_pkg::item_t d_q, d_d;

  always_comb begin
    d_d     = c_q;
    d_d.quo = '0;
    if (c_q.root[15]) begin
      d_d.num = {c_q.pvn, 15'b0} - {15'b0, c_q.pvn};
      d_d.den = c_q.pdr;
    end else begin
      d_d.num = {15'b0, c_q.pvn};
      d_d.den = {16'b0, span};
    end
  end

  logic            dv_vld [0:sdsm_pkg::DivSteps];
  sdsm_pkg::item_t dv_it  [0:sdsm_pkg::DivSteps];
  assign dv_vld[0] = d_valid_q;
  assign dv_it[0]  = d_q;

  for (genvar g = 0; g < sdsm_pkg::DivSteps; g++) begin : g_div
    sdsm_div_cell #(
      .BIT (sdsm_pkg::DivSteps - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_vld[g]),
      .item_i  (dv_it[g]),
      .valid_o (dv_vld[g+1]),
      .item_o  (dv_it[g+1])
    );
  end

  // Stage E: conditioned magnitude and gain product.
  logic            e_valid_q;
  sdsm_pkg::item_t e_q, e_d;
  sdsm_pkg::item_t e_in;

  always_comb begin
    e_in = dv_it[sdsm_pkg::DivSteps];
    e_d  = e_in;
    priority if (dz_q == '0) begin
      e_d.mag = e_in.vmag;
    end else if (e_in.le_dz) begin
      e_d.mag = '0;
    end else begin
      e_d.mag = e_in.quo;
    end
    e_d.gp = 28'(e_d.mag * sens_q);
  end

  // Output stage: saturate and merge with the keys.
  logic [27:0] gshift;
  logic [15:0] gmag;
  logic [15:0] lval;
  logic        take;

  always_comb begin
    gshift = e_q.gp >> SENS_FRAC_BITS;
    if ({1'b0, sens_q} == SensUnity) begin
      gmag = e_q.mag;
    end else if (gshift > {12'b0, sdsm_pkg::AxisMax}) begin
      gmag = sdsm_pkg::AxisMax;
    end else begin
      gmag = gshift[15:0];
    end
    if (e_q.plus && !e_q.minus) begin
      lval = sdsm_pkg::AxisMax;
    end else if (e_q.minus && !e_q.plus) begin
      lval = sdsm_pkg::AxisMinusMax;
    end else begin
      lval = '0;
    end
    take = e_q.active && e_q.vnz && (gmag != '0)
        && ((lval == '0) || (gmag > sdsm_pkg::AxisMax));
    out_data_d = take ? (e_q.vneg ? 16'(-gmag) : gmag) : lval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= s_axis_tvalid;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= sq_vld[sdsm_pkg::SqrtSteps];
      d_valid_q   <= c_valid_q;
      e_valid_q   <= dv_vld[sdsm_pkg::DivSteps];
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q        <= a_d;
      b_q        <= b_d;
      c_q        <= c_d;
      d_q        <= d_d;
      e_q        <= e_d;
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Square root remainder never exceeds twice the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld[sdsm_pkg::SqrtSteps] |->
      ({2'b00, c_in.srem} <= {3'b000, c_in.root, 1'b0}))
    else $error("sqrt remainder out of range");

  // Divider leaves a remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld[sdsm_pkg::DivSteps] |-> (e_in.num < {15'b0, e_in.den}))
    else $error("divider remainder not reduced");

  // Conditioned magnitude never exceeds the raw magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q |-> (e_q.mag <= e_q.vmag))
    else $error("deadzone grew the magnitude");

  // A remote value is only taken when the remote pad is active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_valid_q && !e_q.active && en) |=> (out_data_q == $past(lval)))
    else $error("inactive remote reached the output");

endmodule

// File: tb/tb_axis_checker.sv
// Checker: predicts each axis value from accepted requests and compares results.
module tb_axis_checker (
  input  logic        clk_i,
  input  logic        s_fire_i,
  input  logic [39:0] s_data_i,
  input  logic        s_user_i,
  input  logic        m_fire_i,
  input  logic [15:0] m_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SensFracBits = 8;

  logic [15:0] dz_q = sdsm_pkg::DzReset;
  logic [11:0] sens_q = sdsm_pkg::SensReset;
  logic [15:0] axis_queue[$];
  int          fail_count = 0;
  int          result_count = 0;

  function automatic logic [31:0] int_sqrt(input logic [31:0] val);
    logic [31:0] root;
    logic [31:0] rest;
    logic [31:0] bitv;
    root = 0;
    rest = val;
    bitv = 32'h4000_0000;
    while (bitv > rest) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] merged_axis(input logic [39:0] d, input logic sel_y);
    longint x, y, v, ret, r, dzr, dn, n, nv, ax, ar;
    x = longint'($signed(d[15:0]));
    y = longint'($signed(d[31:16]));
    v = sel_y ? y : x;
    ret = 0;
    if (d[33]) ret = 32767;
    if (d[34]) ret = ret - 32767;
    if (d[32] && v != 0) begin
      if (dz_q != 0) begin
        r = longint'(int_sqrt(32'(x * x + y * y)));
        dzr = (longint'(dz_q) * 32767) >>> 16;
        dn = 32767 - dzr;
        if (r <= dzr) begin
          v = 0;
        end else begin
          n = r - dzr;
          if (n > dn) n = dn;
          if (r <= 32767) v = (v * n) / dn;
          else v = (v * n * 32767) / (dn * r);
        end
      end
      if (v != 0 && sens_q != (12'd1 << SensFracBits)) begin
        nv = (v * longint'(sens_q)) / (longint'(1) << SensFracBits);
        if (nv > 32767) nv = 32767;
        if (nv < -32767) nv = -32767;
        v = nv;
      end
      ax = v < 0 ? -v : v;
      ar = ret < 0 ? -ret : ret;
      if (v != 0 && (ret == 0 || ax > ar)) ret = v;
    end
    return ret[15:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending_o      = axis_queue.size();
  assign fail_count_o   = fail_count;
  assign result_count_o = result_count;

  always @(posedge clk_i) begin
    logic [15:0] want;
    if (m_fire_i) begin
      result_count++;
      if (axis_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected axis value %h", m_data_i));
      end else begin
        want = axis_queue.pop_front();
        if (want !== m_data_i)
          report_mismatch($sformatf("axis_value %h, predicted %h", m_data_i, want));
      end
    end
    if (s_fire_i) axis_queue.push_back(merged_axis(s_data_i, s_user_i));
    if (cfg_we_i) begin
      if (cfg_idx_i == sdsm_pkg::REG_DEADZONE) dz_q <= cfg_data_i;
      else sens_q <= cfg_data_i[11:0];
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top: drives requests and configuration, applies back-pressure, gives the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 38;
  localparam int StallLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = sdsm_pkg::REG_DEADZONE;
  logic [15:0] cfg_data_i = '0;

  int fail_count, pending, result_count;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;

  stick_deadzone_sensitivity_merge_core u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  tb_axis_checker u_checker (
    .clk_i,
    .s_fire_i(s_axis_tvalid && s_axis_tready),
    .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser),
    .m_fire_i(m_axis_tvalid && m_axis_tready),
    .m_data_i(m_axis_tdata),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count),
    .pending_o(pending),
    .result_count_o(result_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold when asked.
  always @(negedge clk_i) begin
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Leaves the request line high after acceptance; the next call lowers it only while it idles, write_reg always.
  task automatic send_request(input logic signed [15:0] sx, input logic signed [15:0] sy,
                              input logic sel_y, input logic act,
                              input logic plus, input logic minus);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, minus, plus, act, sy, sx};
    s_axis_tuser  <= sel_y;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input sdsm_pkg::reg_idx_e idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(16'($urandom_range(40)) - 16'd20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_batch(input int count);
    logic [15:0] sx, sy;
    logic act;
    for (int i = 0; i < count; i++) begin
      sx = pick_axis();
      sy = pick_axis();
      act = ($urandom_range(9) != 0);
      send_request(sx, sy, 1'($urandom_range(1)), act, 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [15:0] dz_set[6] = '{16'd0, 16'd1, 16'd8192, 16'd32768, 16'd65535, 16'd3000};
    logic [15:0] sens_set[6] = '{16'd256, 16'd0, 16'd4095, 16'd128, 16'd700, 16'd255};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes and merge corner cases at reset settings, then with a deadzone and extreme gains.
    send_request(16'h8000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(16'h8000, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0);
    send_request(16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b0, 1'b1);
    send_request(16'h7fff, 16'h7fff, 1'b0, 1'b1, 1'b1, 1'b0);
    send_request(16'h1234, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);
    send_request(16'h1234, 16'h4321, 1'b0, 1'b0, 1'b1, 1'b1);
    send_request(16'h0001, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b1);
    send_request(16'hffff, 16'h0001, 1'b0, 1'b1, 1'b0, 1'b1);
    write_reg(sdsm_pkg::REG_DEADZONE, 16'd16384);
    send_request(16'h0100, 16'h0100, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_request(16'h7fff, 16'h7fff, 1'b0, 1'b1, 1'b1, 1'b0);
    send_request(16'h5000, 16'hb000, 1'b1, 1'b1, 1'b0, 1'b0);
    write_reg(sdsm_pkg::REG_SENSITIVITY, 16'd0);
    send_request(16'h4000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1);
    write_reg(sdsm_pkg::REG_SENSITIVITY, 16'd4095);
    send_request(16'h4000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1);
    send_request(16'hc000, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0);

    for (int ph = 0; ph < 18; ph++) begin
      write_reg(sdsm_pkg::REG_DEADZONE, dz_set[ph % 6]);
      write_reg(sdsm_pkg::REG_SENSITIVITY, sens_set[(ph / 3) % 6]);
      case (ph / 6)
        0: begin send_idle_pct = 20; recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 12) begin
        // Long hold: let the pipeline fill and stall its input.
        fork
          begin
            recv_hold = 1'b1;
            repeat (200) @(negedge clk_i);
            recv_hold = 1'b0;
          end
          random_batch(108);
        join
      end else begin
        random_batch(108);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    $display("tb: %0d results checked across 18 deadzone/gain settings,", result_count);
    $display("tb: with sender and receiver stalls and a long output hold");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sdsm_pkg.sv
hw/rtl/sdsm_sqrt_cell.sv
hw/rtl/sdsm_div_cell.sv
hw/rtl/stick_deadzone_sensitivity_merge_core.sv
tb/tb_axis_checker.sv
tb/tb_top.sv
